>>> rtl/dplc_pkg.sv
// Package for the dual-policy LRU cache model: geometry constants, config
// register indexes and the packed set-row types. No dependencies.
`default_nettype none
package dplc_pkg;
    localparam int MAX_SETS  = 256;
    localparam int MAX_WAYS  = 8;
    localparam int ADDR_BITS = 32;
    localparam int SET_W     = $clog2(MAX_SETS);
    localparam int WAY_W     = $clog2(MAX_WAYS);
    localparam int AGE_W     = 3;
    localparam int TAG_W     = 32;
    localparam int CNT_W     = 32;
    localparam logic [AGE_W-1:0] FILL_AGE = 3'd7;

    localparam logic [1:0] REG_OFFSET_BITS = 2'd0;
    localparam logic [1:0] REG_INDEX_BITS  = 2'd1;
    localparam logic [1:0] REG_WAYS_IN_USE = 2'd2;

    typedef struct packed {
        logic             valid;
        logic             dirty;
        logic [AGE_W-1:0] age;
        logic [TAG_W-1:0] tag;
    } t_line;

    typedef t_line [MAX_WAYS-1:0] t_row;
endpackage
`default_nettype wire

>>> rtl/dual_policy_lru_cache_model_top.sv
// Top level of the dual-policy LRU cache model: two set memories, lookup,
// LRU update and saturating totals. Depends on dplc_pkg.
// An item is accepted at one edge, which also issues the set read to both set
// memories (one row per set, all ways side by side, registered read output).
// The item then passes through the read state to the update state, which
// compares, picks a way, writes the updated row back and loads the result into
// the output register. The input is held off while an item is in flight and
// while a result waits in the output register, so a new item is not accepted
// until the last result has been taken.
// All lines start invalid after reset; there is no clearing pass, since a valid
// flip-flop per set row marks rows never written.
`default_nettype none
module dual_policy_lru_cache_model_top import dplc_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // [31:0] address
    input  wire logic [31:0]  s_axis_tdata,
    // [0] req_type
    input  wire logic         s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [0] wt_hit, [1] wt_mem_refs, [2] wb_hit, [4:3] wb_mem_refs,
    // [36:5] wt_hit_total, [68:37] wt_miss_total, [100:69] wt_ref_total,
    // [132:101] wb_hit_total, [164:133] wb_miss_total, [196:165] wb_ref_total,
    // [199:197] zero
    output logic [199:0]      m_axis_tdata,
    input  wire logic         i_cfg_we,
    input  wire logic [1:0]   i_cfg_index,
    input  wire logic [4:0]   i_cfg_data
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;

    logic [1:0]  r_state;
    logic [4:0]  r_off_bits;
    logic [3:0]  r_idx_bits;
    logic [3:0]  r_ways;
    logic        r_write;
    logic [SET_W-1:0] r_set;
    logic [TAG_W-1:0] r_tag;
    logic [MAX_SETS-1:0] r_row_vld;
    t_row r_wt_mem [MAX_SETS];
    t_row r_wb_mem [MAX_SETS];
    t_row r_wt_rd, r_wb_rd;
    logic [CNT_W-1:0] r_cnt [6];
    logic        r_ovld;
    logic [4:0]  r_oflags;

    // address split
    logic [ADDR_BITS-1:0] addr;
    logic [5:0]  split;
    logic [ADDR_BITS-1:0] sh;
    logic [ADDR_BITS-1:0] imask;
    assign addr  = s_axis_tdata[ADDR_BITS-1:0];
    assign split = {1'b0, r_off_bits} + {2'b0, r_idx_bits};
    assign sh    = addr >> r_off_bits;
    assign imask = ~({ADDR_BITS{1'b1}} << r_idx_bits);

    logic [WAY_W:0] ways;
    assign ways = (r_ways == 4'd0) ? (WAY_W+1)'(1) :
                  (r_ways > 4'(MAX_WAYS)) ? (WAY_W+1)'(MAX_WAYS) : (WAY_W+1)'(r_ways);

    t_row wt_row, wb_row, n_wt_row, n_wb_row;
    logic wt_hit, wb_hit, wt_refs;
    logic [1:0] wb_refs;

    function automatic t_row f_touch(t_row row, logic [WAY_W:0] nw,
                                     logic [WAY_W-1:0] way, logic [AGE_W-1:0] old);
        t_row o;
        o = row;
        for (int v = 0; v < MAX_WAYS; v++)
            if (v < nw && v != way && row[v].valid && row[v].age < old)
                o[v].age = row[v].age + AGE_W'(1);
        o[way].age = '0;
        return o;
    endfunction

    always_comb begin
        logic wh, bh, wf, bf;
        logic [WAY_W-1:0] ww, bw, wfr, bfr, wv, bv;
        wt_row = r_row_vld[r_set] ? r_wt_rd : '0;
        wb_row = r_row_vld[r_set] ? r_wb_rd : '0;
        wh = 1'b0; bh = 1'b0; wf = 1'b0; bf = 1'b0;
        ww = '0; bw = '0; wfr = '0; bfr = '0; wv = '0; bv = '0;
        for (int w = MAX_WAYS-1; w >= 0; w--) begin
            if (w < ways) begin
                if (wt_row[w].valid && wt_row[w].tag == r_tag) begin
                    wh = 1'b1; ww = WAY_W'(w);
                end
                if (wb_row[w].valid && wb_row[w].tag == r_tag) begin
                    bh = 1'b1; bw = WAY_W'(w);
                end
                if (!wt_row[w].valid) begin wf = 1'b1; wfr = WAY_W'(w); end
                if (!wb_row[w].valid) begin bf = 1'b1; bfr = WAY_W'(w); end
            end
        end
        for (int w = 1; w < MAX_WAYS; w++) begin
            if (w < ways) begin
                if (wt_row[w].age > wt_row[wv].age) wv = WAY_W'(w);
                if (wb_row[w].age > wb_row[bv].age) bv = WAY_W'(w);
            end
        end
        wt_hit = wh; wb_hit = bh;
        n_wt_row = wt_row;
        if (wh) begin
            n_wt_row = f_touch(wt_row, ways, ww, wt_row[ww].age);
            wt_refs = r_write;
        end else begin
            wt_refs = 1'b1;
            if (!r_write) begin
                if (wf) begin
                    n_wt_row = f_touch(wt_row, ways, wfr, FILL_AGE);
                    wv = wfr;
                end else begin
                    n_wt_row = f_touch(wt_row, ways, wv, wt_row[wv].age);
                end
                n_wt_row[wv].tag = r_tag;
                n_wt_row[wv].valid = 1'b1;
            end
        end
        n_wb_row = wb_row;
        if (bh) begin
            n_wb_row = f_touch(wb_row, ways, bw, wb_row[bw].age);
            if (r_write) n_wb_row[bw].dirty = 1'b1;
            wb_refs = 2'd0;
        end else begin
            wb_refs = 2'd1;
            if (bf) begin
                n_wb_row = f_touch(wb_row, ways, bfr, FILL_AGE);
                bv = bfr;
            end else begin
                if (wb_row[bv].dirty) wb_refs = 2'd2;
                n_wb_row = f_touch(wb_row, ways, bv, wb_row[bv].age);
            end
            n_wb_row[bv].tag = r_tag;
            n_wb_row[bv].valid = 1'b1;
            n_wb_row[bv].dirty = r_write;
        end
    end

    function automatic logic [CNT_W-1:0] f_sat(logic [CNT_W-1:0] c, logic [1:0] n);
        logic [CNT_W:0] s;
        s = {1'b0, c} + (CNT_W+1)'(n);
        return s[CNT_W] ? '1 : s[CNT_W-1:0];
    endfunction

    assign s_axis_tready = (r_state == ST_IDLE) && !r_ovld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_off_bits <= 5'd4;
            r_idx_bits <= 4'd4;
            r_ways <= 4'd1;
            r_row_vld <= '0;
            r_ovld <= 1'b0;
            for (int i = 0; i < 6; i++) r_cnt[i] <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_OFFSET_BITS: r_off_bits <= i_cfg_data;
                    REG_INDEX_BITS:  r_idx_bits <= i_cfg_data[3:0];
                    REG_WAYS_IN_USE: r_ways <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) r_ovld <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_write <= s_axis_tuser;
                        r_set <= SET_W'(sh & imask);
                        r_tag <= (split >= 6'd32) ? '0 : TAG_W'(addr >> split);
                        r_state <= ST_READ;
                    end
                end
                ST_READ: r_state <= ST_UPD;
                ST_UPD: begin
                    r_row_vld[r_set] <= 1'b1;
                    r_cnt[0] <= f_sat(r_cnt[0], {1'b0, wt_hit});
                    r_cnt[1] <= f_sat(r_cnt[1], {1'b0, !wt_hit});
                    r_cnt[2] <= f_sat(r_cnt[2], {1'b0, wt_refs});
                    r_cnt[3] <= f_sat(r_cnt[3], {1'b0, wb_hit});
                    r_cnt[4] <= f_sat(r_cnt[4], {1'b0, !wb_hit});
                    r_cnt[5] <= f_sat(r_cnt[5], wb_refs);
                    r_oflags <= {wb_refs, wb_hit, wt_refs, wt_hit};
                    r_ovld <= 1'b1;
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE) begin
            r_wt_rd <= r_wt_mem[SET_W'(sh & imask)];
            r_wb_rd <= r_wb_mem[SET_W'(sh & imask)];
        end
        if (r_state == ST_UPD) begin
            r_wt_mem[r_set] <= n_wt_row;
            r_wb_mem[r_set] <= n_wb_row;
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata = {3'b0, r_cnt[5], r_cnt[4], r_cnt[3], r_cnt[2], r_cnt[1],
                           r_cnt[0], r_oflags};
endmodule
`default_nettype wire

>>> rtl/dplc_checker.sv
// Port-level checker for the dual-policy LRU cache model, bound to the top.
// Depends on dual_policy_lru_cache_model_top.
`default_nettype none
module dplc_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [199:0] m_axis_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped while stalled");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second item taken while busy");
    a_nout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("item taken while result pending");
    a_refs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[4:3] != 2'd3 &&
        (m_axis_tdata[2] == 1'b0 || m_axis_tdata[4:3] == 2'd0))
        else $error("bad write-back reference count");
endmodule
bind dual_policy_lru_cache_model_top dplc_checker u_dplc_checker (.*);
`default_nettype wire

>>> tb/tb_dual_policy_lru_cache_model_top.sv
// Self-checking testbench for dual_policy_lru_cache_model_top: streams read and write
// accesses, predicts both caches and the running totals, and checks every result item.
// Depends on dplc_pkg and the top-level RTL.
`timescale 1ns / 1ps
module tb_dual_policy_lru_cache_model_top;
    import dplc_pkg::*;

    typedef struct {
        logic        wt_hit;
        logic        wt_refs;
        logic        wb_hit;
        logic [1:0]  wb_refs;
        logic [31:0] totals [6];
    } access_result_t;

    typedef struct {
        logic        is_write;
        logic [31:0] addr;
    } access_t;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [31:0]  s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [199:0] m_axis_tdata;
    logic         i_cfg_we = 1'b0;
    logic [1:0]   i_cfg_index = '0;
    logic [4:0]   i_cfg_data = '0;

    dual_policy_lru_cache_model_top dut (
        .i_clk, .i_rst_n,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .i_cfg_we, .i_cfg_index, .i_cfg_data
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // mirror of both caches: index 0 write-through, index 1 write-back
    logic [31:0] line_tag   [2][MAX_SETS*MAX_WAYS];
    logic        line_valid [2][MAX_SETS*MAX_WAYS];
    logic        line_dirty [MAX_SETS*MAX_WAYS];
    logic [2:0]  line_age   [2][MAX_SETS*MAX_WAYS];
    logic [31:0] run_totals [6];
    int          cfg_offset = 4;
    int          cfg_index  = 4;
    int          cfg_ways   = 1;

    access_t        pending_accesses [$];
    access_result_t expected_results [$];
    int             errors = 0;
    bit             quiet = 1'b0;

    function automatic int find_hit(int c, int base, int ways, logic [31:0] tag);
        int w;
        find_hit = -1;
        for (w = ways - 1; w >= 0; w--)
            if (line_valid[c][base+w] && line_tag[c][base+w] == tag)
                find_hit = w;
    endfunction

    function automatic int pick_fill_way(int c, int base, int ways, output int old);
        int w;
        int best;
        best = -1;
        for (w = ways - 1; w >= 0; w--)
            if (!line_valid[c][base+w])
                best = w;
        if (best >= 0) begin
            old = FILL_AGE;
            return best;
        end
        best = 0;
        for (w = 1; w < ways; w++)
            if (line_age[c][base+w] > line_age[c][base+best])
                best = w;
        old = line_age[c][base+best];
        return best;
    endfunction

    task automatic touch_line(int c, int base, int ways, int way, int old);
        int v;
        for (v = 0; v < ways; v++)
            if (v != way && line_valid[c][base+v] && line_age[c][base+v] < old)
                line_age[c][base+v] = line_age[c][base+v] + 3'd1;
        line_age[c][base+way] = '0;
    endtask

    task automatic predict_access(access_t acc);
        logic [63:0]    a;
        logic [31:0]    tag;
        logic [63:0]    sh;
        int             ways, split, base, w, old, k;
        logic [32:0]    sum;
        int             incr [6];
        access_result_t r;
        a = {32'b0, acc.addr};
        ways = cfg_ways == 0 ? 1 : (cfg_ways > MAX_WAYS ? MAX_WAYS : cfg_ways);
        split = cfg_offset + cfg_index;
        tag = split >= 64 ? 32'd0 : 32'(a >> split);
        sh = a >> cfg_offset;
        base = int'(8'(sh & ((64'd1 << cfg_index) - 64'd1))) * MAX_WAYS;
        r.wt_hit = 0; r.wt_refs = 0; r.wb_hit = 0; r.wb_refs = 0;

        w = find_hit(0, base, ways, tag);
        if (w >= 0) begin
            r.wt_hit = 1;
            touch_line(0, base, ways, w, line_age[0][base+w]);
            r.wt_refs = acc.is_write;
        end else begin
            r.wt_refs = 1;
            if (!acc.is_write) begin
                w = pick_fill_way(0, base, ways, old);
                touch_line(0, base, ways, w, old);
                line_tag[0][base+w] = tag;
                line_valid[0][base+w] = 1;
            end
        end

        w = find_hit(1, base, ways, tag);
        if (w >= 0) begin
            r.wb_hit = 1;
            touch_line(1, base, ways, w, line_age[1][base+w]);
            if (acc.is_write)
                line_dirty[base+w] = 1;
        end else begin
            r.wb_refs = 1;
            w = pick_fill_way(1, base, ways, old);
            if (line_valid[1][base+w] && line_dirty[base+w])
                r.wb_refs = 2;
            touch_line(1, base, ways, w, old);
            line_tag[1][base+w] = tag;
            line_valid[1][base+w] = 1;
            line_dirty[base+w] = acc.is_write;
        end

        incr = '{int'(r.wt_hit), 1 - int'(r.wt_hit), int'(r.wt_refs),
                 int'(r.wb_hit), 1 - int'(r.wb_hit), int'(r.wb_refs)};
        for (k = 0; k < 6; k++) begin
            sum = {1'b0, run_totals[k]} + 33'(incr[k]);
            run_totals[k] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            r.totals[k] = run_totals[k];
        end
        expected_results.push_back(r);
    endtask

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic int draw_gap();
        if (quiet || $urandom_range(0, 2) != 0)
            return 0;
        return $urandom_range(0, 19);
    endfunction

    // driver
    int      tx_gap = 0;
    access_t tx_cur;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_access(tx_cur);
                tx_gap = draw_gap();
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_accesses.size() > 0) begin
                    tx_cur = pending_accesses.pop_front();
                    s_axis_tdata <= tx_cur.addr;
                    s_axis_tuser <= tx_cur.is_write;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    int rx_gap = 0;
    always @(posedge i_clk) begin
        access_result_t e;
        int k;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    report("unexpected item", 32'(m_axis_tdata), 32'd0);
                end else begin
                    e = expected_results.pop_front();
                    if (m_axis_tdata[0] !== e.wt_hit)
                        report("wt_hit", 32'(m_axis_tdata[0]), 32'(e.wt_hit));
                    if (m_axis_tdata[1] !== e.wt_refs)
                        report("wt_mem_refs", 32'(m_axis_tdata[1]), 32'(e.wt_refs));
                    if (m_axis_tdata[2] !== e.wb_hit)
                        report("wb_hit", 32'(m_axis_tdata[2]), 32'(e.wb_hit));
                    if (m_axis_tdata[4:3] !== e.wb_refs)
                        report("wb_mem_refs", 32'(m_axis_tdata[4:3]), 32'(e.wb_refs));
                    for (k = 0; k < 6; k++)
                        if (m_axis_tdata[5+32*k +: 32] !== e.totals[k])
                            report($sformatf("total %0d", k),
                                   m_axis_tdata[5+32*k +: 32], e.totals[k]);
                end
                rx_gap = draw_gap();
            end
            if (rx_gap > 0) begin
                rx_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic add_access(bit wr, logic [31:0] addr);
        access_t acc;
        acc.is_write = wr;
        acc.addr = addr;
        pending_accesses.push_back(acc);
    endtask

    function automatic logic [31:0] random_addr();
        logic [63:0] a;
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        a = 64'($urandom_range(0, 11)) << (cfg_offset + cfg_index);
        a |= 64'($urandom_range(0, 3)) << cfg_offset;
        a |= 64'($urandom) & ((64'd1 << cfg_offset) - 64'd1);
        return a[31:0];
    endfunction

    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_accesses.size() > 0 || expected_results.size() > 0 || s_axis_tvalid);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, int value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= 5'(value);
        case (idx)
            REG_OFFSET_BITS: cfg_offset = value & 31;
            REG_INDEX_BITS:  cfg_index = value & 15;
            default:         cfg_ways = value & 15;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    int phase_cfg [7][3] = '{
        '{0, 0, 8}, '{16, 8, 8}, '{2, 3, 4}, '{31, 15, 15},
        '{5, 2, 0}, '{6, 1, 3}, '{3, 8, 2}
    };

    initial begin
        int p, n;
        for (n = 0; n < 6; n++) run_totals[n] = '0;
        for (n = 0; n < MAX_SETS * MAX_WAYS; n++) begin
            line_valid[0][n] = 0; line_valid[1][n] = 0; line_dirty[n] = 0;
            line_age[0][n] = '0; line_age[1][n] = '0;
            line_tag[0][n] = '0; line_tag[1][n] = '0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_access(0, 32'h0);
        add_access(0, 32'h0);
        add_access(1, 32'h4);
        add_access(0, 32'h100);
        add_access(1, 32'h100);
        add_access(1, 32'h200);
        add_access(1, 32'hFFFF_FFFF);
        add_access(1, 32'hFFFF_FFFF);
        add_access(0, 32'hFFFF_FFF0);
        add_access(0, 32'h7FFF_FFFF);
        add_access(1, 32'h8000_0000);
        add_access(0, 32'h8000_0000);
        add_access(0, 32'h0000_0010);
        add_access(1, 32'h0000_0110);
        for (n = 0; n < 160; n++)
            add_access($urandom_range(0, 1), random_addr());
        wait_idle();

        for (p = 0; p < 7; p++) begin
            write_reg(REG_OFFSET_BITS, phase_cfg[p][0]);
            write_reg(REG_INDEX_BITS, phase_cfg[p][1]);
            write_reg(REG_WAYS_IN_USE, phase_cfg[p][2]);
            quiet = (p % 3 == 1);
            for (n = 0; n < 175; n++)
                add_access($urandom_range(0, 1), random_addr());
            wait_idle();
        end

        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #20ms;
        $display("FAILURE");
        $finish;
    end
endmodule

>>> filelist.f
rtl/dplc_pkg.sv
rtl/dual_policy_lru_cache_model_top.sv
rtl/dplc_checker.sv
tb/tb_dual_policy_lru_cache_model_top.sv
